// File: rtl/core/ssdd_pkg.sv
package ssdd_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 20;
  localparam int LIMIT_W         = 16;
  localparam int BOUND_W         = 20;
  localparam int PATH_W          = 32;
  localparam int HEAD_W          = 16;

  localparam int MUL_W   = 34;
  localparam int MUL_H   = MUL_W / 2;
  localparam int RAD_W   = 2 * MUL_W;
  localparam int DOT_W   = 47;
  localparam int DEN_W   = 46;
  localparam int NUM_W   = 61;
  localparam int Q_W     = 16;
  localparam int EXC_W   = 37;
  localparam int CW      = 48;
  localparam int ACC_W   = 22;

  localparam int VEC_BITS     = 22;
  localparam int NORM_BITS    = 40;
  localparam int NORM_COARSE  = 8;
  localparam int CORDIC_STEPS = 18;

  localparam logic [16:0] ONE_Q       = 17'd16384;
  localparam logic [15:0] PI_Q        = 16'd51472;
  localparam int          HALF_PI_ANG = 411775;

  localparam logic [15:0] CORNER_LIMIT_RST = 16'd4915;
  localparam logic [19:0] CHORD_MIN_RST    = 20'd4800;
  localparam logic [19:0] CHORD_MAX_RST    = 20'd8000;
  localparam logic [19:0] EXP_EXCESS_RST   = 20'd1008;
  localparam logic [19:0] EXC_TOL_RST      = 20'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_LIMIT = 3'd0,
    REG_CHORD_MIN    = 3'd1,
    REG_CHORD_MAX    = 3'd2,
    REG_EXP_EXCESS   = 3'd3,
    REG_EXC_TOL      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MS_AA = 3'd0,
    MS_BB = 3'd1,
    MS_XX = 3'd2,
    MS_YY = 3'd3,
    MS_LL = 3'd4
  } msel_t;

  typedef enum logic [1:0] {
    TAG_LU    = 2'd0,
    TAG_LV    = 2'd1,
    TAG_DIST  = 2'd2,
    TAG_CHORD = 2'd3
  } tag_t;

  typedef struct packed {
    logic  open_seg;
    logic  red_step;
    logic  hload;
    logic  mul_run;
    msel_t msel;
    logic  sq_run;
    tag_t  tag;
    logic  div_run;
    logic  close_seg;
    logic  cord_init;
    logic  cord_norm;
    logic  cord_step;
    logic  shift_pts;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic pts_ge2;
    logic seg_open;
    logic last;
    logic red_done;
    logic mul_done;
    logic sq_done;
    logic len_zero;
    logic div_done;
    logic corner;
    logic match;
    logic norm_done;
    logic m_zero;
    logic cord_done;
    logic out_busy;
  } sts_t;

  function automatic logic [17:0] atan_ang(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0:    r = 18'd205887;
      5'd1:    r = 18'd121542;
      5'd2:    r = 18'd64220;
      5'd3:    r = 18'd32599;
      5'd4:    r = 18'd16363;
      5'd5:    r = 18'd8189;
      5'd6:    r = 18'd4096;
      5'd7:    r = 18'd2048;
      5'd8:    r = 18'd1024;
      5'd9:    r = 18'd512;
      5'd10:   r = 18'd256;
      5'd11:   r = 18'd128;
      5'd12:   r = 18'd64;
      5'd13:   r = 18'd32;
      5'd14:   r = 18'd16;
      5'd15:   r = 18'd8;
      5'd16:   r = 18'd4;
      5'd17:   r = 18'd2;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/ssdd_in_if.sv
interface ssdd_in_if #(
  parameter int COORD_WIDTH = ssdd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// File: rtl/core/ssdd_out_if.sv
interface ssdd_out_if #(
  parameter int COORD_WIDTH = ssdd_pkg::COORD_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               dock_found;
  logic signed [COORD_WIDTH-1:0]      dock_x;
  logic signed [COORD_WIDTH-1:0]      dock_y;
  logic [ssdd_pkg::HEAD_W-1:0]        dock_heading;

  modport source (output valid, dock_found, dock_x, dock_y, dock_heading, input ready);
  modport sink   (input valid, dock_found, dock_x, dock_y, dock_heading, output ready);
endinterface

// File: rtl/core/scan_segment_dock_detector_unit.sv
// Channel   Dir  Beat contents                               Handshake
// in_ch     in   point_x, point_y, last_point                valid/ready
// out_ch    out  dock_found, dock_x, dock_y, dock_heading    valid/ready
// cfg_*     in   cfg_index, cfg_wdata                        cfg_we, no wait
//
// One point at a time. The first two points of a scan are only shifted in; a later point
// takes three hypot runs, the products and a 16-step divide (both skipped when a length
// is zero), control states, plus vector halving steps when coordinates are wide.
// Closing on the last point adds a chord hypot and a test; at a corner the chord hypot is
// the third run. A match adds normalization and an 18-step CORDIC, a last point the beat.
// Reset is synchronous and active low and restores the register defaults.
// A result waits in an output register; only the next result stalls on out_ch.ready.
module scan_segment_dock_detector_unit #(
  parameter int COORD_WIDTH = ssdd_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ssdd_in_if.sink                           in_ch,
  ssdd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ssdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssdd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ssdd_pkg::cmd_t cmd;
  ssdd_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  ssdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssdd_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_ch.valid && in_ready),
    .in_x        (in_ch.point_x),
    .in_y        (in_ch.point_y),
    .in_last     (in_ch.last_point),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_found   (out_ch.dock_found),
    .out_x       (out_ch.dock_x),
    .out_y       (out_ch.dock_y),
    .out_heading (out_ch.dock_heading),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: rtl/core/ssdd_ctrl.sv
module ssdd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssdd_pkg::sts_t   sts,
  output ssdd_pkg::cmd_t   cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_OPEN  = 19'h00002,
    S_RED   = 19'h00004,
    S_HLD   = 19'h00008,
    S_HMA   = 19'h00010,
    S_HMB   = 19'h00020,
    S_HSQ   = 19'h00040,
    S_ZCHK  = 19'h00080,
    S_DMX   = 19'h00100,
    S_DMY   = 19'h00200,
    S_DML   = 19'h00400,
    S_DIV   = 19'h00800,
    S_DEC   = 19'h01000,
    S_TEST  = 19'h02000,
    S_CINIT = 19'h04000,
    S_CNORM = 19'h08000,
    S_CITER = 19'h10000,
    S_SHIFT = 19'h20000,
    S_FIN   = 19'h40000
  } state_t;

  state_t          state_r, state_nxt;
  ssdd_pkg::tag_t  tag_r, tag_nxt;
  logic            ck_last_r, ck_last_nxt;
  state_t          after_close;

  always_comb begin
    after_close = ck_last_r ? S_FIN : S_SHIFT;
    state_nxt   = state_r;
    tag_nxt     = tag_r;
    ck_last_nxt = ck_last_r;
    cmd         = '0;
    cmd.tag     = tag_r;
    cmd.msel    = ssdd_pkg::MS_AA;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = sts.pts_ge2 ? S_OPEN : S_SHIFT;
        end
      end
      S_OPEN: begin
        cmd.open_seg = 1'b1;
        state_nxt    = S_RED;
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (sts.red_done) begin
          tag_nxt   = ssdd_pkg::TAG_LU;
          state_nxt = S_HLD;
        end
      end
      S_HLD: begin
        cmd.hload = 1'b1;
        state_nxt = S_HMA;
      end
      S_HMA: begin
        cmd.mul_run = 1'b1;
        cmd.msel    = ssdd_pkg::MS_AA;
        if (sts.mul_done) state_nxt = S_HMB;
      end
      S_HMB: begin
        cmd.mul_run = 1'b1;
        cmd.msel    = ssdd_pkg::MS_BB;
        if (sts.mul_done) state_nxt = S_HSQ;
      end
      S_HSQ: begin
        cmd.sq_run = 1'b1;
        if (sts.sq_done) begin
          case (tag_r)
            ssdd_pkg::TAG_LU: begin
              tag_nxt   = ssdd_pkg::TAG_LV;
              state_nxt = S_HLD;
            end
            ssdd_pkg::TAG_LV:   state_nxt = S_ZCHK;
            ssdd_pkg::TAG_DIST: state_nxt = S_SHIFT;
            default:            state_nxt = S_TEST;
          endcase
        end
      end
      S_ZCHK: begin
        if (sts.len_zero) begin
          tag_nxt   = ssdd_pkg::TAG_DIST;
          state_nxt = S_HLD;
        end else begin
          state_nxt = S_DMX;
        end
      end
      S_DMX: begin
        cmd.mul_run = 1'b1;
        cmd.msel    = ssdd_pkg::MS_XX;
        if (sts.mul_done) state_nxt = S_DMY;
      end
      S_DMY: begin
        cmd.mul_run = 1'b1;
        cmd.msel    = ssdd_pkg::MS_YY;
        if (sts.mul_done) state_nxt = S_DML;
      end
      S_DML: begin
        cmd.mul_run = 1'b1;
        cmd.msel    = ssdd_pkg::MS_LL;
        if (sts.mul_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_HLD;
        if (sts.corner) begin
          ck_last_nxt = 1'b0;
          tag_nxt     = ssdd_pkg::TAG_CHORD;
        end else begin
          tag_nxt = ssdd_pkg::TAG_DIST;
        end
      end
      S_TEST: begin
        cmd.close_seg = 1'b1;
        state_nxt     = sts.match ? S_CINIT : after_close;
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        state_nxt     = S_CNORM;
      end
      S_CNORM: begin
        cmd.cord_norm = 1'b1;
        if (sts.m_zero) begin
          state_nxt = after_close;
        end else if (sts.norm_done) begin
          state_nxt = S_CITER;
        end
      end
      S_CITER: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_done) state_nxt = after_close;
      end
      S_SHIFT: begin
        cmd.shift_pts = 1'b1;
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.seg_open) begin
          ck_last_nxt = 1'b1;
          tag_nxt     = ssdd_pkg::TAG_CHORD;
          state_nxt   = S_HLD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tag_r     <= ssdd_pkg::TAG_LU;
      ck_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tag_r     <= tag_nxt;
      ck_last_r <= ck_last_nxt;
    end
  end

endmodule

// File: rtl/core/ssdd_dp.sv
module ssdd_dp #(
  parameter int COORD_WIDTH = ssdd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ssdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssdd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_fire,
  input  logic signed [COORD_WIDTH-1:0]       in_x,
  input  logic signed [COORD_WIDTH-1:0]       in_y,
  input  logic                                in_last,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic [ssdd_pkg::HEAD_W-1:0]         out_heading,
  input  ssdd_pkg::cmd_t                      cmd,
  output ssdd_pkg::sts_t                      sts
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int MW    = ssdd_pkg::MUL_W;
  localparam int MH    = ssdd_pkg::MUL_H;
  localparam int RW    = ssdd_pkg::RAD_W;
  localparam int DOTW  = ssdd_pkg::DOT_W;
  localparam int DENW  = ssdd_pkg::DEN_W;
  localparam int NUMW  = ssdd_pkg::NUM_W;
  localparam int QW    = ssdd_pkg::Q_W;
  localparam int EXW   = ssdd_pkg::EXC_W;
  localparam int CW    = ssdd_pkg::CW;
  localparam int AW    = ssdd_pkg::ACC_W;
  localparam int PW    = ssdd_pkg::PATH_W;
  localparam int HW    = ssdd_pkg::HEAD_W;

  function automatic logic [DW-1:0] magf(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // Configuration registers.
  logic [ssdd_pkg::LIMIT_W-1:0] corner_limit_r;
  logic [ssdd_pkg::BOUND_W-1:0] chord_min_r, chord_max_r, exp_excess_r, exc_tol_r;

  // Scan state.
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic                          last_r;
  logic signed [COORD_WIDTH-1:0] older_x_r, older_y_r, newer_x_r, newer_y_r;
  logic signed [COORD_WIDTH-1:0] start_x_r, start_y_r;
  logic [PW-1:0]                 path_r;
  logic                          seg_open_r;
  logic [1:0]                    pts_r;
  logic                          match_valid_r;
  logic signed [COORD_WIDTH-1:0] match_x_r, match_y_r;
  logic [HW-1:0]                 match_head_r;

  // Neighbor vectors as magnitude and sign.
  logic [DW-1:0] umx_r, umy_r, vmx_r, vmy_r;
  logic          usx_r, usy_r, vsx_r, vsy_r;

  logic [MW-1:0]   ha_r, hb_r;
  logic [1:0]      mcnt_r;
  logic [RW-1:0]   macc_r;
  logic [RW-1:0]   rad_r;
  logic [5:0]      sqcnt_r;
  logic [MW-1:0]   srem_r, sroot_r;
  logic [MW-1:0]   lu_r, lv_r, chord_r;
  logic signed [DOTW-1:0] dot_r;
  logic [DENW-1:0] den_r;
  logic [NUMW-1:0] drem_r;
  logic [3:0]      dcnt_r;
  logic [QW-1:0]   q_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [AW-1:0] cacc_r;
  logic [4:0]      ccnt_r;

  logic                          out_valid_r, out_found_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic [HW-1:0]                 out_head_r;

  // Combinational helpers.
  logic signed [DW-1:0] ux_d, uy_d, vx_d, vy_d, sx_d, sy_d, cxs_d, cys_d;
  logic                 big_u, big_v;
  logic [MW-1:0]        ma, mb;
  logic [MH-1:0]        ahalf, bhalf;
  logic [2*MH-1:0]      pp;
  logic [RW-1:0]        pp_sh, mprod;
  logic [1:0]           rbits;
  logic [MW+1:0]        srem_sh, strial, srem_sub;
  logic                 sq_take;
  logic [MW-1:0]        sroot_nxt;
  logic signed [DOTW-1:0] dterm;
  logic [DOTW-1:0]      dot_mag;
  logic [NUMW-1:0]      dsh;
  logic                 dbit;
  logic [QW-1:0]        qc;
  logic [16:0]          opc;
  logic [PW+2:0]        psum;
  logic signed [EXW-1:0] exc;
  logic [EXW-1:0]       exc_mag;
  logic                 match_ok;
  logic signed [CW-1:0] cstep_x, cstep_y, cx_nxt, cy_nxt;
  logic signed [AW-1:0] cang, cacc_nxt, hsum;
  logic [AW-1:0]        hq;
  logic [HW-1:0]        head_val;
  logic                 norm_ok, coarse_ok;
  logic                 mul_done, sq_done, div_done, cord_done;

  always_comb begin
    ux_d  = DW'(older_x_r) - DW'(newer_x_r);
    uy_d  = DW'(older_y_r) - DW'(newer_y_r);
    vx_d  = DW'(px_r) - DW'(newer_x_r);
    vy_d  = DW'(py_r) - DW'(newer_y_r);
    sx_d  = DW'(newer_x_r) - DW'(px_r);
    sy_d  = DW'(newer_y_r) - DW'(py_r);
    cxs_d = DW'(start_x_r) - DW'(newer_x_r);
    cys_d = DW'(start_y_r) - DW'(newer_y_r);
    big_u = (|(umx_r >> ssdd_pkg::VEC_BITS)) || (|(umy_r >> ssdd_pkg::VEC_BITS));
    big_v = (|(vmx_r >> ssdd_pkg::VEC_BITS)) || (|(vmy_r >> ssdd_pkg::VEC_BITS));

    // Multiplier: four 17x17 partial products, one per cycle.
    case (cmd.msel)
      ssdd_pkg::MS_AA: begin ma = ha_r;        mb = ha_r;        end
      ssdd_pkg::MS_BB: begin ma = hb_r;        mb = hb_r;        end
      ssdd_pkg::MS_XX: begin ma = MW'(umx_r);  mb = MW'(vmx_r);  end
      ssdd_pkg::MS_YY: begin ma = MW'(umy_r);  mb = MW'(vmy_r);  end
      ssdd_pkg::MS_LL: begin ma = lu_r;        mb = lv_r;        end
      default:         begin ma = '0;          mb = '0;          end
    endcase
    ahalf = mcnt_r[0] ? ma[MW-1:MH] : ma[MH-1:0];
    bhalf = mcnt_r[1] ? mb[MW-1:MH] : mb[MH-1:0];
    pp    = ahalf * bhalf;
    case (mcnt_r)
      2'd0:    pp_sh = RW'(pp);
      2'd3:    pp_sh = RW'(pp) << (2 * MH);
      default: pp_sh = RW'(pp) << MH;
    endcase
    mprod    = ((mcnt_r == 2'd0) ? '0 : macc_r) + pp_sh;
    mul_done = cmd.mul_run && (mcnt_r == 2'd3);

    // Square root: one result bit per cycle.
    rbits     = rad_r[RW-1 -: 2];
    srem_sh   = {((sqcnt_r == 6'd0) ? '0 : srem_r), rbits};
    strial    = {((sqcnt_r == 6'd0) ? '0 : sroot_r), 2'b01};
    sq_take   = srem_sh >= strial;
    srem_sub  = sq_take ? (srem_sh - strial) : srem_sh;
    sroot_nxt = {((sqcnt_r == 6'd0) ? {(MW-1){1'b0}} : sroot_r[MW-2:0]), sq_take};
    sq_done   = cmd.sq_run && (sqcnt_r == 6'(MW - 1));

    dterm   = signed'({1'b0, mprod[DOTW-2:0]});
    dot_mag = dot_r[DOTW-1] ? DOTW'(-dot_r) : DOTW'(dot_r);

    // Restoring divide, quotient bits from the top.
    dsh      = NUMW'(den_r) << (4'd15 - dcnt_r);
    dbit     = drem_r >= dsh;
    div_done = cmd.div_run && (dcnt_r == 4'd15);

    qc  = (q_r > QW'(ssdd_pkg::ONE_Q)) ? QW'(ssdd_pkg::ONE_Q) : q_r;
    opc = dot_r[DOTW-1] ? (ssdd_pkg::ONE_Q - 17'(qc)) : (ssdd_pkg::ONE_Q + 17'(qc));

    psum = (PW+3)'(path_r) + (PW+3)'(sroot_nxt);

    exc      = signed'(EXW'(path_r)) - signed'(EXW'(chord_r)) - signed'(EXW'(exp_excess_r));
    exc_mag  = exc[EXW-1] ? EXW'(-exc) : EXW'(exc);
    match_ok = (chord_r > MW'(chord_min_r)) && (chord_r < MW'(chord_max_r))
            && (exc_mag < EXW'(exc_tol_r));

    // CORDIC vectoring step.
    norm_ok   = (|(cx_r >>> ssdd_pkg::NORM_BITS)) || (|(cy_r >>> ssdd_pkg::NORM_BITS));
    coarse_ok = (|(cx_r >>> (ssdd_pkg::NORM_BITS - ssdd_pkg::NORM_COARSE)))
             || (|(cy_r >>> (ssdd_pkg::NORM_BITS - ssdd_pkg::NORM_COARSE)));
    cstep_x   = cy_r >>> ccnt_r;
    cstep_y   = cx_r >>> ccnt_r;
    cang      = signed'(AW'(ssdd_pkg::atan_ang(ccnt_r)));
    if (cy_r > 0) begin
      cx_nxt   = cx_r + cstep_x;
      cy_nxt   = cy_r - cstep_y;
      cacc_nxt = cacc_r + cang;
    end else begin
      cx_nxt   = cx_r - cstep_x;
      cy_nxt   = cy_r + cstep_y;
      cacc_nxt = cacc_r - cang;
    end
    cord_done = cmd.cord_step && (ccnt_r == 5'(ssdd_pkg::CORDIC_STEPS - 1));
    hsum      = cacc_nxt + AW'(8);
    hq        = AW'(hsum >>> 4);
    if (cacc_nxt[AW-1]) begin
      head_val = '0;
    end else if (hq > AW'(ssdd_pkg::PI_Q)) begin
      head_val = ssdd_pkg::PI_Q;
    end else begin
      head_val = hq[HW-1:0];
    end
  end

  always_comb begin
    sts           = '0;
    sts.pts_ge2   = pts_r[1];
    sts.seg_open  = seg_open_r;
    sts.last      = last_r;
    sts.red_done  = !big_u && !big_v;
    sts.mul_done  = mul_done;
    sts.sq_done   = sq_done;
    sts.len_zero  = (lu_r == '0) || (lv_r == '0);
    sts.div_done  = div_done;
    sts.corner    = opc > 17'(corner_limit_r);
    sts.match     = match_ok;
    sts.norm_done = norm_ok;
    sts.m_zero    = (cx_r == '0) && (cy_r == '0);
    sts.cord_done = cord_done;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r   <= in_x;
      py_r   <= in_y;
      last_r <= in_last;
    end

    if (cmd.open_seg) begin
      if (!seg_open_r) begin
        start_x_r <= newer_x_r;
        start_y_r <= newer_y_r;
        path_r    <= '0;
      end
      umx_r <= magf(ux_d);  usx_r <= ux_d[DW-1];
      umy_r <= magf(uy_d);  usy_r <= uy_d[DW-1];
      vmx_r <= magf(vx_d);  vsx_r <= vx_d[DW-1];
      vmy_r <= magf(vy_d);  vsy_r <= vy_d[DW-1];
    end

    if (cmd.red_step) begin
      if (big_u) begin
        umx_r <= umx_r >> 1;
        umy_r <= umy_r >> 1;
      end
      if (big_v) begin
        vmx_r <= vmx_r >> 1;
        vmy_r <= vmy_r >> 1;
      end
    end

    if (cmd.hload) begin
      case (cmd.tag)
        ssdd_pkg::TAG_LU:   begin ha_r <= MW'(umx_r);       hb_r <= MW'(umy_r);       end
        ssdd_pkg::TAG_LV:   begin ha_r <= MW'(vmx_r);       hb_r <= MW'(vmy_r);       end
        ssdd_pkg::TAG_DIST: begin ha_r <= MW'(magf(sx_d));  hb_r <= MW'(magf(sy_d));  end
        default:            begin ha_r <= MW'(magf(cxs_d)); hb_r <= MW'(magf(cys_d)); end
      endcase
    end

    macc_r <= mprod;
    if (mul_done) begin
      case (cmd.msel)
        ssdd_pkg::MS_AA: rad_r <= mprod;
        ssdd_pkg::MS_BB: rad_r <= rad_r + mprod;
        ssdd_pkg::MS_XX: dot_r <= (usx_r ^ vsx_r) ? -dterm : dterm;
        ssdd_pkg::MS_YY: dot_r <= dot_r + ((usy_r ^ vsy_r) ? -dterm : dterm);
        ssdd_pkg::MS_LL: begin
          den_r  <= mprod[DENW-1:0];
          drem_r <= NUMW'(dot_mag) << 14;
        end
        default: ;
      endcase
    end else if (cmd.sq_run) begin
      rad_r <= rad_r << 2;
    end

    if (cmd.sq_run) begin
      srem_r  <= srem_sub[MW-1:0];
      sroot_r <= sroot_nxt;
    end
    if (sq_done) begin
      case (cmd.tag)
        ssdd_pkg::TAG_LU:   lu_r <= sroot_nxt;
        ssdd_pkg::TAG_LV:   lv_r <= sroot_nxt;
        ssdd_pkg::TAG_DIST: path_r <= (|psum[PW+2:PW]) ? '1 : psum[PW-1:0];
        default:            chord_r <= sroot_nxt;
      endcase
    end

    if (cmd.div_run) begin
      if (dbit) drem_r <= drem_r - dsh;
      q_r <= {q_r[QW-2:0], dbit};
    end

    if (cmd.close_seg && match_ok) begin
      match_x_r    <= newer_x_r;
      match_y_r    <= newer_y_r;
      match_head_r <= '0;
    end

    if (cmd.cord_init) begin
      if (cxs_d[DW-1]) begin
        cx_r   <= signed'(CW'(magf(cys_d)));
        cy_r   <= signed'(CW'(magf(cxs_d)));
        cacc_r <= AW'(ssdd_pkg::HALF_PI_ANG);
      end else begin
        cx_r   <= CW'(cxs_d);
        cy_r   <= signed'(CW'(magf(cys_d)));
        cacc_r <= '0;
      end
    end else if (cmd.cord_norm && !norm_ok) begin
      if (coarse_ok) begin
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end else begin
        cx_r <= cx_r <<< ssdd_pkg::NORM_COARSE;
        cy_r <= cy_r <<< ssdd_pkg::NORM_COARSE;
      end
    end else if (cmd.cord_step) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cacc_r <= cacc_nxt;
    end
    if (cord_done) match_head_r <= head_val;

    if (cmd.shift_pts) begin
      older_x_r <= newer_x_r;
      older_y_r <= newer_y_r;
      newer_x_r <= px_r;
      newer_y_r <= py_r;
    end

    if (cmd.finish) begin
      out_found_r <= match_valid_r;
      out_x_r     <= match_valid_r ? match_x_r : '0;
      out_y_r     <= match_valid_r ? match_y_r : '0;
      out_head_r  <= match_valid_r ? match_head_r : '0;
    end

    if (!rst_n) begin
      corner_limit_r <= ssdd_pkg::CORNER_LIMIT_RST;
      chord_min_r    <= ssdd_pkg::CHORD_MIN_RST;
      chord_max_r    <= ssdd_pkg::CHORD_MAX_RST;
      exp_excess_r   <= ssdd_pkg::EXP_EXCESS_RST;
      exc_tol_r      <= ssdd_pkg::EXC_TOL_RST;
      pts_r          <= '0;
      seg_open_r     <= 1'b0;
      match_valid_r  <= 1'b0;
      out_valid_r    <= 1'b0;
      mcnt_r         <= '0;
      sqcnt_r        <= '0;
      dcnt_r         <= '0;
      ccnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (ssdd_pkg::cfg_reg_t'(cfg_index))
          ssdd_pkg::REG_CORNER_LIMIT: corner_limit_r <= cfg_wdata[ssdd_pkg::LIMIT_W-1:0];
          ssdd_pkg::REG_CHORD_MIN:    chord_min_r    <= cfg_wdata;
          ssdd_pkg::REG_CHORD_MAX:    chord_max_r    <= cfg_wdata;
          ssdd_pkg::REG_EXP_EXCESS:   exp_excess_r   <= cfg_wdata;
          ssdd_pkg::REG_EXC_TOL:      exc_tol_r      <= cfg_wdata;
          default: ;
        endcase
      end
      mcnt_r  <= cmd.mul_run   ? mcnt_r + 2'd1  : '0;
      sqcnt_r <= cmd.sq_run    ? sqcnt_r + 6'd1 : '0;
      dcnt_r  <= cmd.div_run   ? dcnt_r + 4'd1  : '0;
      ccnt_r  <= cmd.cord_step ? ccnt_r + 5'd1  : '0;
      if (cmd.open_seg) seg_open_r <= 1'b1;
      if (cmd.close_seg) begin
        seg_open_r <= 1'b0;
        if (match_ok) match_valid_r <= 1'b1;
      end
      if (cmd.shift_pts && !pts_r[1]) pts_r <= pts_r + 2'd1;
      if (cmd.finish) begin
        out_valid_r   <= 1'b1;
        pts_r         <= '0;
        seg_open_r    <= 1'b0;
        match_valid_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_heading = out_head_r;

  a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ready))
    else $error("result beat overwritten while waiting");

  a_cordic_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cord_step |-> norm_ok)
    else $error("CORDIC started on an unnormalized vector");

  a_shift_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_pts |=> pts_r != 2'd0)
    else $error("point count did not advance");

  a_match_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.close_seg && match_ok) |=> match_valid_r)
    else $error("matching segment not recorded");

endmodule
